// File: hw/rtl/czd_pkg.sv
// ----------------------------------------------------------------------------
// czd_pkg
// Shared constants and types for the zero-pair/zero-run COBS frame decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package czd_pkg;

  localparam int BYTE_W  = 8;
  localparam int LIMIT_W = 16;
  localparam int ZCNT_W  = 4;

  localparam logic [BYTE_W-1:0]  CODE_DIFF    = 8'hD2;
  localparam logic [BYTE_W-1:0]  CODE_RUN_LO  = 8'hD3;
  localparam logic [BYTE_W-1:0]  CODE_RUN_HI  = 8'hDF;
  localparam logic [BYTE_W-1:0]  CODE_PAIR_LO = 8'hE0;
  localparam logic [BYTE_W-1:0]  DIFF_LEN     = CODE_DIFF - 8'd1;
  localparam logic [ZCNT_W-1:0]  PAIR_ZEROS   = 4'd2;
  localparam logic [ZCNT_W-1:0]  ONE_ZERO     = 4'd1;
  localparam logic [LIMIT_W-1:0] LIMIT_RST    = 16'd1024;

  // controller -> datapath
  typedef struct packed {
    logic accept;     // take the input beat
    logic zero_step;  // produce one zero of a pending run
    logic finish;     // emit frame end result, clear frame state
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic out_free;   // output register can take a result this cycle
    logic run_start;  // accepted beat leaves a zero run to produce
    logic zcnt_one;   // last zero of the run
  } status_t;

endpackage

`default_nettype wire

// File: hw/rtl/cobs_zpe_decoder.sv
// ----------------------------------------------------------------------------
// cobs_zpe_decoder
// COBS decoder with zero-pair and zero-run codes, one frame byte per beat.
//
//   channel | direction | handshake          | payload
//   in      | input     | in_valid/in_stall  | in_byte, in_last
//   out     | output    | out_valid/out_stall| out_byte, out_byte_present,
//           |           |                    | out_frame_end, out_limit_error
//   cfg     | input     | cfg_valid/cfg_ready| cfg_data (output limit)
//
// A data byte or block code needs only its accept step; a beat that releases
// zeros (a zero-run, one-zero or zero-pair code without data, or the final data
// byte of a block) is followed by one zero step per zero, one zero through the holdback per cycle
// while the output is not stalled, and the frame's last beat adds a finish step for the frame end result.
// The output register is a single stage; a stalled output holds the sequencer.
// Synchronous active-low reset; output limit resets to 1024.
// ----------------------------------------------------------------------------
`default_nettype none

module cobs_zpe_decoder (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [czd_pkg::BYTE_W-1:0]  in_byte,
  input  wire logic                        in_last,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [czd_pkg::BYTE_W-1:0]       out_byte,
  output logic                             out_byte_present,
  output logic                             out_frame_end,
  output logic                             out_limit_error,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [czd_pkg::LIMIT_W-1:0] cfg_data
);

  czd_pkg::cmd_t    cmd;
  czd_pkg::status_t st;

  assign cfg_ready = 1'b1;

  czd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_last  (in_last),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  czd_datapath u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .st               (st),
    .in_byte          (in_byte),
    .cfg_we           (cfg_valid && cfg_ready),
    .cfg_data         (cfg_data),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_byte         (out_byte),
    .out_byte_present (out_byte_present),
    .out_frame_end    (out_frame_end),
    .out_limit_error  (out_limit_error)
  );

endmodule

`default_nettype wire

// File: hw/rtl/czd_ctrl.sv
// ----------------------------------------------------------------------------
// czd_ctrl
// Sequencer: accepts beats, walks zero runs, closes the frame.
// ----------------------------------------------------------------------------
`default_nettype none

module czd_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  input  wire logic            in_last,
  output logic                 in_stall,
  input  czd_pkg::status_t     st,
  output czd_pkg::cmd_t        cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_ZEROS,
    S_FINISH
  } state_t;

  state_t state_r, state_nxt;
  logic   last_r, last_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    last_nxt  = last_r;
    in_stall  = !(state_r == S_IDLE && st.out_free);
    unique case (state_r)
      S_IDLE: begin
        if (in_valid && st.out_free) begin
          cmd.accept = 1'b1;
          last_nxt   = in_last;
          if (st.run_start)
            state_nxt = S_ZEROS;
          else if (in_last)
            state_nxt = S_FINISH;
        end
      end
      S_ZEROS: begin
        if (st.out_free) begin
          cmd.zero_step = 1'b1;
          if (st.zcnt_one)
            state_nxt = last_r ? S_FINISH : S_IDLE;
        end
      end
      S_FINISH: begin
        if (st.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      last_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      last_r  <= last_nxt;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/czd_datapath.sv
// ----------------------------------------------------------------------------
// czd_datapath
// Block decode, holdback byte, length count and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module czd_datapath (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  czd_pkg::cmd_t                       cmd,
  output czd_pkg::status_t                    st,
  input  wire logic [czd_pkg::BYTE_W-1:0]     in_byte,
  input  wire logic                           cfg_we,
  input  wire logic [czd_pkg::LIMIT_W-1:0]    cfg_data,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic [czd_pkg::BYTE_W-1:0]          out_byte,
  output logic                                out_byte_present,
  output logic                                out_frame_end,
  output logic                                out_limit_error
);

  logic [czd_pkg::LIMIT_W-1:0] limit_r;
  logic [czd_pkg::BYTE_W-1:0]  data_left_r, data_left_nxt;
  logic [czd_pkg::ZCNT_W-1:0]  zafter_r, zafter_nxt;
  logic [czd_pkg::ZCNT_W-1:0]  zcnt_r, zcnt_nxt;
  logic                        held_valid_r, held_valid_nxt;
  logic [czd_pkg::BYTE_W-1:0]  held_r, held_nxt;
  logic [czd_pkg::LIMIT_W-1:0] count_r, count_nxt;
  logic                        out_valid_r;

  logic [czd_pkg::BYTE_W-1:0]  d_code;
  logic [czd_pkg::ZCNT_W-1:0]  z_code;
  logic [czd_pkg::ZCNT_W-1:0]  zload;
  logic                        zload_en;
  logic                        prod_en;
  logic [czd_pkg::BYTE_W-1:0]  prod_val;
  logic                        emit;
  logic                        out_take;

  // code byte -> data length and trailing zeros
  always_comb begin
    priority if (in_byte == czd_pkg::CODE_DIFF) begin
      d_code = czd_pkg::DIFF_LEN;
      z_code = '0;
    end else if (in_byte >= czd_pkg::CODE_RUN_LO && in_byte <= czd_pkg::CODE_RUN_HI) begin
      d_code = '0;
      z_code = in_byte[czd_pkg::ZCNT_W-1:0];
    end else if (in_byte >= czd_pkg::CODE_PAIR_LO) begin
      d_code = {3'b000, in_byte[4:0]};
      z_code = czd_pkg::PAIR_ZEROS;
    end else if (in_byte == '0) begin
      d_code = '0;
      z_code = czd_pkg::ONE_ZERO;
    end else begin
      d_code = in_byte - 8'd1;
      z_code = czd_pkg::ONE_ZERO;
    end
  end

  always_comb begin
    data_left_nxt  = data_left_r;
    zafter_nxt     = zafter_r;
    zload          = '0;
    zload_en       = 1'b0;
    prod_en        = 1'b0;
    prod_val       = in_byte;

    if (cmd.accept) begin
      if (data_left_r == '0) begin
        if (d_code == '0) begin
          zload      = z_code;
          zload_en   = 1'b1;
          zafter_nxt = '0;
        end else begin
          data_left_nxt = d_code;
          zafter_nxt    = z_code;
        end
      end else begin
        prod_en       = 1'b1;
        data_left_nxt = data_left_r - 8'd1;
        if (data_left_r == 8'd1) begin
          zload      = zafter_r;
          zload_en   = 1'b1;
          zafter_nxt = '0;
        end
      end
    end
    if (cmd.zero_step) begin
      prod_en  = 1'b1;
      prod_val = '0;
    end

    if (zload_en)
      zcnt_nxt = zload;
    else if (cmd.zero_step)
      zcnt_nxt = zcnt_r - 4'd1;
    else
      zcnt_nxt = zcnt_r;

    // holdback: the previous byte leaves as the new one enters
    held_valid_nxt = held_valid_r;
    held_nxt       = held_r;
    count_nxt      = count_r;
    if (prod_en) begin
      if (count_r < limit_r) begin
        held_valid_nxt = 1'b1;
        held_nxt       = prod_val;
        count_nxt      = count_r + 16'd1;
      end else begin
        held_valid_nxt = 1'b0;
      end
    end

    if (cmd.finish) begin
      data_left_nxt  = '0;
      zafter_nxt     = '0;
      zcnt_nxt       = '0;
      held_valid_nxt = 1'b0;
      count_nxt      = '0;
    end
  end

  assign emit     = prod_en && held_valid_r;
  assign out_take = out_valid_r && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r      <= czd_pkg::LIMIT_RST;
      data_left_r  <= '0;
      zafter_r     <= '0;
      zcnt_r       <= '0;
      held_valid_r <= 1'b0;
      count_r      <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we)
        limit_r <= cfg_data;
      data_left_r  <= data_left_nxt;
      zafter_r     <= zafter_nxt;
      zcnt_r       <= zcnt_nxt;
      held_valid_r <= held_valid_nxt;
      count_r      <= count_nxt;
      if (emit || cmd.finish)
        out_valid_r <= 1'b1;
      else if (out_take)
        out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    held_r <= held_nxt;
    if (emit) begin
      out_byte         <= held_r;
      out_byte_present <= 1'b1;
      out_frame_end    <= 1'b0;
      out_limit_error  <= 1'b0;
    end else if (cmd.finish) begin
      out_byte         <= '0;
      out_byte_present <= 1'b0;
      out_frame_end    <= 1'b1;
      out_limit_error  <= (count_r >= limit_r);
    end
  end

  assign out_valid    = out_valid_r;
  assign st.out_free  = !out_valid_r || !out_stall;
  assign st.run_start = zload_en && (zload != '0);
  assign st.zcnt_one  = (zcnt_r == 4'd1);

endmodule

`default_nettype wire

// File: hw/rtl/czd_checker.sv
// ----------------------------------------------------------------------------
// czd_checker
// Port-level checks on the decoder's result stream.
// ----------------------------------------------------------------------------
`default_nettype none

module czd_checker (
  input wire logic                        clk,
  input wire logic                        rst_n,
  input wire logic                        out_valid,
  input wire logic                        out_stall,
  input wire logic [czd_pkg::BYTE_W-1:0]  out_byte,
  input wire logic                        out_byte_present,
  input wire logic                        out_frame_end,
  input wire logic                        out_limit_error
);

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_byte) &&
      $stable(out_byte_present) && $stable(out_frame_end) && $stable(out_limit_error))
    else $error("stalled result beat changed");

  // a beat is either a data byte or the frame end status, never both or neither
  a_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_byte_present != out_frame_end))
    else $error("result beat kind malformed");

  // limit error only on the frame end
  a_err_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_limit_error |-> out_frame_end)
    else $error("limit error outside frame end");

  // nothing is pending from a frame once its end has been delivered
  a_end_drains: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_end && !out_stall |=> !out_valid)
    else $error("result follows frame end directly");

endmodule

bind cobs_zpe_decoder czd_checker u_czd_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_byte         (out_byte),
  .out_byte_present (out_byte_present),
  .out_frame_end    (out_frame_end),
  .out_limit_error  (out_limit_error)
);

`default_nettype wire
